### rtl/core/i2cram_pkg.sv
package i2cram_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT   = 2'd2;

    localparam logic [7:0]  DEV_ADDR_RESET    = 8'd208;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;
    localparam logic [7:0]  ACK_LIMIT_RESET   = 8'd250;

    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_READ      = 2'd1;
    localparam logic [1:0] OP_READ_PAIR = 2'd2;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    localparam logic [7:0] MSB_MASK = 8'h80;
    localparam logic [3:0] BIT_LAST = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_STA0 = 5'd1,
        PH_STA1 = 5'd2,
        PH_STA2 = 5'd3,
        PH_STA3 = 5'd4,
        PH_TX0  = 5'd5,
        PH_TX1  = 5'd6,
        PH_TX2  = 5'd7,
        PH_ACKW = 5'd8,
        PH_ACKL = 5'd9,
        PH_RX0  = 5'd10,
        PH_RX1  = 5'd11,
        PH_NK0  = 5'd12,
        PH_NK1  = 5'd13,
        PH_NK2  = 5'd14,
        PH_STP0 = 5'd15,
        PH_STP1 = 5'd16,
        PH_STP2 = 5'd17,
        PH_AST0 = 5'd18,
        PH_AST1 = 5'd19,
        PH_AST2 = 5'd20
    } phase_t;

    // one bus tick after classification
    typedef struct packed {
        logic       start;
        logic [1:0] opcode;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  dev_addr;
        logic [15:0] phase_ticks;
        logic [7:0]  ack_limit;
    } cfg_t;

    typedef struct packed {
        logic        ack_missed;
        logic [15:0] read_data;
        logic        done_res;
        logic        busy_res;
        logic        sda_low;
        logic        scl_out;
    } result_t;

endpackage

### rtl/core/i2cram_front.sv
module i2cram_front (
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [i2cram_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                            queue_full,
    output logic                            push,
    output i2cram_pkg::cmd_t                cmd
);
    import i2cram_pkg::*;

    logic       req_valid;
    logic [1:0] opcode;

    assign req_valid = s_axis_tdata[0];
    assign opcode    = s_axis_tdata[2:1];

    assign s_axis_tready = ~queue_full;
    assign push          = s_axis_tvalid & ~queue_full;

    // a request with the reserved opcode starts no transfer here; it still goes into the queue as a bus tick
    assign cmd.start      = req_valid & (opcode != OP_RESERVED);
    assign cmd.opcode     = opcode;
    assign cmd.reg_addr   = s_axis_tdata[10:3];
    assign cmd.write_data = s_axis_tdata[18:11];
    assign cmd.sda_in     = s_axis_tdata[19];

endmodule

### rtl/core/i2cram_queue.sv
module i2cram_queue #(
    parameter int DEPTH = i2cram_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  i2cram_pkg::cmd_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output i2cram_pkg::cmd_t head_data
);
    import i2cram_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/i2cram_seq.sv
module i2cram_seq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  i2cram_pkg::cfg_t                 cfg,
    input  logic                             head_valid,
    input  i2cram_pkg::cmd_t                 head_data,
    output logic                             pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [i2cram_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import i2cram_pkg::*;

    typedef struct packed {
        phase_t     phase;
        logic       load;
        logic [7:0] shift;
    } op_entry_t;

    // first phase of a transaction step, and the byte it shifts if any
    function automatic op_entry_t begin_op(
        input logic [1:0] op,
        input logic [2:0] step,
        input logic [7:0] reg_sel,
        input logic [7:0] data,
        input logic [7:0] dev
    );
        op_entry_t e;
        e.phase = PH_STP0;
        e.load  = 1'b0;
        e.shift = 8'd0;
        if (op == OP_WRITE) begin
            case (step)
                3'd0: e.phase = PH_STA0;
                3'd1: begin e.phase = PH_TX0; e.load = 1'b1; e.shift = dev;     end
                3'd2: begin e.phase = PH_TX0; e.load = 1'b1; e.shift = reg_sel; end
                3'd3: begin e.phase = PH_TX0; e.load = 1'b1; e.shift = data;    end
                default: e.phase = PH_STP0;
            endcase
        end else begin
            case (step)
                3'd0, 3'd3: e.phase = PH_STA0;
                3'd1: begin e.phase = PH_TX0; e.load = 1'b1; e.shift = dev;     end
                3'd2: begin e.phase = PH_TX0; e.load = 1'b1; e.shift = reg_sel; end
                3'd4: begin e.phase = PH_TX0; e.load = 1'b1; e.shift = dev + 8'd1; end
                3'd5: begin e.phase = PH_RX0; e.load = 1'b1; e.shift = 8'd0;    end
                3'd6: e.phase = PH_NK0;
                default: e.phase = PH_STP0;
            endcase
        end
        return e;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [2:0]  byte_step_reg, byte_step_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  ack_wait_reg, ack_wait_next;
    logic [15:0] result_reg, result_next;
    logic [1:0]  lat_op_reg, lat_op_next;
    logic [7:0]  lat_addr_reg, lat_addr_next;
    logic [7:0]  lat_data_reg, lat_data_next;
    logic        second_reg, second_next;
    logic        m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic        step;
    logic        scl, low, busy, done, miss;
    logic [15:0] rd;
    logic        tx_low;
    logic [15:0] pt_eff;
    logic [7:0]  lim_eff;
    logic        qend;
    logic [7:0]  reg_sel;
    logic [2:0]  step_inc;
    op_entry_t   bo;
    logic [7:0]  ack_inc;
    logic [3:0]  bit_inc;
    logic [7:0]  rx_byte;
    result_t     res;

    // one bus tick per cycle while a request waits at the queue head and the output register can take a result
    assign step = head_valid & (~m_valid_reg | m_axis_tready);
    assign pop  = step;

    assign tx_low   = ((shift_reg & MSB_MASK) == 8'd0);
    assign pt_eff   = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
    assign lim_eff  = (cfg.ack_limit == 8'd0) ? 8'd1 : cfg.ack_limit;
    assign qend     = ({1'b0, tick_reg} + 17'd1) >= {1'b0, pt_eff};
    assign reg_sel  = lat_addr_reg + {7'd0, second_reg};
    assign step_inc = byte_step_reg + 3'd1;
    assign bo       = begin_op(lat_op_reg, step_inc, reg_sel, lat_data_reg, cfg.dev_addr);
    assign ack_inc  = ack_wait_reg + 8'd1;
    assign bit_inc  = bit_cnt_reg + 4'd1;
    assign rx_byte  = {shift_reg[6:0], head_data.sda_in};

    // bus levels of the current phase
    always_comb begin
        scl  = 1'b1;
        low  = 1'b0;
        busy = 1'b1;
        unique case (phase_reg)
            PH_STA0:                            scl = 1'b0;
            PH_STA2:                            low = 1'b1;
            PH_STA3:                  begin scl = 1'b0; low = 1'b1; end
            PH_TX0, PH_TX2:           begin scl = 1'b0; low = tx_low; end
            PH_TX1:                             low = tx_low;
            PH_ACKL, PH_RX0, PH_NK0, PH_NK2:    scl = 1'b0;
            PH_STP0, PH_AST0:         begin scl = 1'b0; low = 1'b1; end
            PH_STP1, PH_AST1:                   low = 1'b1;
            PH_STA1, PH_ACKW, PH_RX1, PH_NK1, PH_STP2, PH_AST2: ;
            default:                            busy = 1'b0;
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_step_next = byte_step_reg;
        shift_next     = shift_reg;
        tick_next      = tick_reg;
        ack_wait_next  = ack_wait_reg;
        result_next    = result_reg;
        lat_op_next    = lat_op_reg;
        lat_addr_next  = lat_addr_reg;
        lat_data_next  = lat_data_reg;
        second_next    = second_reg;
        done           = 1'b0;
        miss           = 1'b0;
        rd             = 16'd0;

        if (phase_reg == PH_ACKW) begin
            if (!head_data.sda_in) begin
                phase_next = PH_ACKL;
                tick_next  = 16'd0;
            end else begin
                ack_wait_next = ack_inc;
                if (ack_inc >= lim_eff) begin
                    phase_next = PH_AST0;
                    tick_next  = 16'd0;
                end
            end
        end else if (!busy) begin
            phase_next = PH_IDLE;
            if (head_data.start) begin
                lat_op_next    = head_data.opcode;
                lat_addr_next  = head_data.reg_addr;
                lat_data_next  = head_data.write_data;
                second_next    = 1'b0;
                result_next    = 16'd0;
                byte_step_next = 3'd0;
                phase_next     = PH_STA0;
                tick_next      = 16'd0;
            end
        end else if (!qend) begin
            tick_next = tick_reg + 16'd1;
        end else begin
            tick_next = 16'd0;
            unique case (phase_reg)
                PH_STA3, PH_ACKL, PH_NK2: begin
                    byte_step_next = step_inc;
                    phase_next     = bo.phase;
                    if (bo.load) begin
                        shift_next   = bo.shift;
                        bit_cnt_next = 4'd0;
                    end
                end
                PH_TX2: begin
                    shift_next   = {shift_reg[6:0], 1'b0};
                    bit_cnt_next = bit_inc;
                    if (bit_inc >= BIT_LAST) begin
                        ack_wait_next = 8'd0;
                        phase_next    = PH_ACKW;
                    end else begin
                        phase_next = PH_TX0;
                    end
                end
                PH_RX1: begin
                    shift_next   = rx_byte;
                    bit_cnt_next = bit_inc;
                    if (bit_inc >= BIT_LAST) begin
                        if (lat_op_reg == OP_READ_PAIR && !second_reg) begin
                            result_next = {rx_byte, 8'd0};
                        end else if (lat_op_reg == OP_READ_PAIR) begin
                            result_next = {result_reg[15:8], rx_byte};
                        end else begin
                            result_next = {8'd0, rx_byte};
                        end
                        byte_step_next = step_inc;
                        phase_next     = bo.phase;
                        if (bo.load) begin
                            shift_next   = bo.shift;
                            bit_cnt_next = 4'd0;
                        end
                    end else begin
                        phase_next = PH_RX0;
                    end
                end
                PH_STP2: begin
                    // the pair read runs a second full read before finishing
                    if (lat_op_reg == OP_READ_PAIR && !second_reg) begin
                        second_next    = 1'b1;
                        byte_step_next = 3'd0;
                        phase_next     = PH_STA0;
                    end else begin
                        done       = 1'b1;
                        rd         = result_reg;
                        phase_next = PH_IDLE;
                    end
                end
                PH_AST2: begin
                    done       = 1'b1;
                    miss       = 1'b1;
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = phase_t'(phase_reg + 5'd1);
                end
            endcase
        end
    end

    assign res.scl_out    = scl;
    assign res.sda_low    = low;
    assign res.busy_res   = busy;
    assign res.done_res   = done;
    assign res.read_data  = rd;
    assign res.ack_missed = miss;

    assign m_valid_next = step | (m_valid_reg & ~m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_cnt_reg   <= '0;
            byte_step_reg <= '0;
            shift_reg     <= '0;
            tick_reg      <= '0;
            ack_wait_reg  <= '0;
            result_reg    <= '0;
            lat_op_reg    <= '0;
            lat_addr_reg  <= '0;
            lat_data_reg  <= '0;
            second_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (step) begin
                phase_reg     <= phase_next;
                bit_cnt_reg   <= bit_cnt_next;
                byte_step_reg <= byte_step_next;
                shift_reg     <= shift_next;
                tick_reg      <= tick_next;
                ack_wait_reg  <= ack_wait_next;
                result_reg    <= result_next;
                lat_op_reg    <= lat_op_next;
                lat_addr_reg  <= lat_addr_next;
                lat_data_reg  <= lat_data_next;
                second_reg    <= second_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg <= M_TDATA_W'(res);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

### rtl/core/i2c_register_access_master_unit.sv
// channel    | dir | tdata fields, lowest bit first
// s_axis     | in  | req_valid[0] opcode[2:1] reg_addr[10:3] write_data[18:11] sda_in[19]
// m_axis     | out | scl_out[0] sda_low[1] busy_res[2] done_res[3] read_data[19:4]
//            |     | ack_missed[20]
// cfg        | in  | 0 device_write_address, 1 phase_ticks, 2 ack_wait_limit
//
// one request is one bus tick; one tick is taken every cycle while a request waits
// and the output is not stalled, and gives one result; on its way to a result a
// request passes the queue entry, then the sequencer and output register
// the queue holds QUEUE_DEPTH requests, so the input keeps flowing that long while
// the output stalls
// synchronous active-low reset puts the bus idle and the config registers at defaults
module i2c_register_access_master_unit #(
    parameter int QUEUE_DEPTH = i2cram_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // req_valid, opcode, reg_addr, write_data, sda_in
    input  logic [i2cram_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // scl_out, sda_low, busy_res, done_res, read_data, ack_missed
    output logic [i2cram_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [i2cram_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cram_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import i2cram_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic queue_full;
    logic push;
    cmd_t cmd;
    logic pop;
    logic head_valid;
    cmd_t head_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_DEV_ADDR:    cfg_next.dev_addr    = cfg_wdata[7:0];
                CFG_PHASE_TICKS: cfg_next.phase_ticks = cfg_wdata;
                CFG_ACK_LIMIT:   cfg_next.ack_limit   = cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dev_addr    <= DEV_ADDR_RESET;
            cfg_reg.phase_ticks <= PHASE_TICKS_RESET;
            cfg_reg.ack_limit   <= ACK_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    i2cram_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .queue_full    (queue_full),
        .push          (push),
        .cmd           (cmd)
    );

    i2cram_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    i2cram_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .head_valid    (head_valid),
        .head_data     (head_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### rtl/core/i2cram_checker.sv
module i2cram_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [i2cram_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import i2cram_pkg::*;

    result_t res;

    assign res = result_t'(m_axis_tdata[$bits(result_t)-1:0]);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a finishing tick is still a busy tick
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && res.done_res |-> res.busy_res)
        else $error("done without busy");

    a_miss_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && res.ack_missed |-> res.done_res && res.read_data == 16'd0)
        else $error("ack miss without done or with data");

endmodule

bind i2c_register_access_master_unit i2cram_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/i2cram_tb_pkg.sv
package i2cram_tb_pkg;

    import i2cram_pkg::*;

    // one bus tick as packed on s_axis_tdata, lowest field at the bottom
    typedef struct packed {
        logic       sda_in;
        logic [7:0] write_data;
        logic [7:0] reg_addr;
        logic [1:0] opcode;
        logic       req_valid;
    } bus_tick_t;

    // position in the byte sequence of a transfer
    localparam logic [2:0] SEQ_START   = 3'd0;
    localparam logic [2:0] SEQ_DEV_WR  = 3'd1;
    localparam logic [2:0] SEQ_REG     = 3'd2;
    localparam logic [2:0] SEQ_DATA    = 3'd3;
    localparam logic [2:0] SEQ_RESTART = 3'd3;
    localparam logic [2:0] SEQ_DEV_RD  = 3'd4;
    localparam logic [2:0] SEQ_RECV    = 3'd5;
    localparam logic [2:0] SEQ_NACK    = 3'd6;

    class bus_level_scoreboard;
        logic [7:0]  dev_addr;
        logic [15:0] quarter_len;
        logic [7:0]  ack_limit;

        phase_t      ph;
        logic [3:0]  bit_cnt;
        logic [2:0]  seq_pos;
        logic [7:0]  shreg;
        logic [15:0] tick_cnt;
        logic [7:0]  ack_cnt;
        logic [15:0] word;
        logic [1:0]  op_l;
        logic [7:0]  addr_l;
        logic [7:0]  data_l;
        logic        on_second;

        result_t     levels_q[$];
        int          errors;
        int          results_seen;

        function new();
            dev_addr    = DEV_ADDR_RESET;
            quarter_len = PHASE_TICKS_RESET;
            ack_limit   = ACK_LIMIT_RESET;
            ph          = PH_IDLE;
            bit_cnt     = '0;
            seq_pos     = '0;
            shreg       = '0;
            tick_cnt    = '0;
            ack_cnt     = '0;
            word        = '0;
            op_l        = '0;
            addr_l      = '0;
            data_l      = '0;
            on_second   = 1'b0;
            errors      = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DEV_ADDR:    dev_addr = val[7:0];
                CFG_PHASE_TICKS: quarter_len = val;
                CFG_ACK_LIMIT:   ack_limit = val[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return levels_q.size();
        endfunction

        function void enter(phase_t p);
            ph = p;
            tick_cnt = '0;
        endfunction

        function void load_byte(logic [7:0] b);
            shreg = b;
            bit_cnt = '0;
            enter(PH_TX0);
        endfunction

        function void begin_seq();
            logic [7:0] reg_sel;
            reg_sel = addr_l + {7'b0, on_second};
            if (op_l == OP_WRITE) begin
                case (seq_pos)
                    SEQ_START:  enter(PH_STA0);
                    SEQ_DEV_WR: load_byte(dev_addr);
                    SEQ_REG:    load_byte(reg_sel);
                    SEQ_DATA:   load_byte(data_l);
                    default:    enter(PH_STP0);
                endcase
            end else begin
                case (seq_pos)
                    SEQ_START, SEQ_RESTART: enter(PH_STA0);
                    SEQ_DEV_WR: load_byte(dev_addr);
                    SEQ_REG:    load_byte(reg_sel);
                    SEQ_DEV_RD: load_byte(dev_addr + 8'd1);
                    SEQ_RECV: begin
                        shreg = '0;
                        bit_cnt = '0;
                        enter(PH_RX0);
                    end
                    SEQ_NACK:   enter(PH_NK0);
                    default:    enter(PH_STP0);
                endcase
            end
        endfunction

        function void next_seq();
            seq_pos = seq_pos + 3'd1;
            begin_seq();
        endfunction

        // advance one tick and queue the line levels it must show
        function void take_tick(bus_tick_t t);
            result_t     r;
            logic [15:0] qlen;
            logic [7:0]  lim;
            logic        qend;
            logic        txlow;
            qlen  = (quarter_len == 16'd0) ? 16'd1 : quarter_len;
            lim   = (ack_limit == 8'd0) ? 8'd1 : ack_limit;
            qend  = ({1'b0, tick_cnt} + 17'd1) >= {1'b0, qlen};
            txlow = (shreg & MSB_MASK) == 8'h00;
            r = '0;
            r.scl_out  = 1'b1;
            r.busy_res = 1'b1;
            case (ph)
                PH_STA0: r.scl_out = 1'b0;
                PH_STA2: r.sda_low = 1'b1;
                PH_STA3: begin
                    r.scl_out = 1'b0;
                    r.sda_low = 1'b1;
                end
                PH_TX0, PH_TX2: begin
                    r.scl_out = 1'b0;
                    r.sda_low = txlow;
                end
                PH_TX1: r.sda_low = txlow;
                PH_ACKL, PH_RX0, PH_NK0, PH_NK2: r.scl_out = 1'b0;
                PH_STP0, PH_AST0: begin
                    r.scl_out = 1'b0;
                    r.sda_low = 1'b1;
                end
                PH_STP1, PH_AST1: r.sda_low = 1'b1;
                PH_STA1, PH_ACKW, PH_RX1, PH_NK1, PH_STP2, PH_AST2: ;
                default: r.busy_res = 1'b0;
            endcase

            if (ph == PH_ACKW) begin
                // ack window: sampled every tick, no quarter timing
                if (!t.sda_in) begin
                    enter(PH_ACKL);
                end else begin
                    ack_cnt = ack_cnt + 8'd1;
                    if (ack_cnt >= lim) enter(PH_AST0);
                end
            end else if (!r.busy_res) begin
                ph = PH_IDLE;
                if (t.req_valid && t.opcode != OP_RESERVED) begin
                    op_l      = t.opcode;
                    addr_l    = t.reg_addr;
                    data_l    = t.write_data;
                    on_second = 1'b0;
                    word      = '0;
                    seq_pos   = SEQ_START;
                    begin_seq();
                end
            end else if (!qend) begin
                tick_cnt = tick_cnt + 16'd1;
            end else begin
                tick_cnt = '0;
                case (ph)
                    PH_STA3, PH_ACKL, PH_NK2: next_seq();
                    PH_TX2: begin
                        shreg = shreg << 1;
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= BIT_LAST) begin
                            ack_cnt = '0;
                            enter(PH_ACKW);
                        end else begin
                            enter(PH_TX0);
                        end
                    end
                    PH_RX1: begin
                        shreg = {shreg[6:0], t.sda_in};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= BIT_LAST) begin
                            if (op_l == OP_READ_PAIR && !on_second)
                                word = {shreg, 8'h00};
                            else if (op_l == OP_READ_PAIR)
                                word = {word[15:8], shreg};
                            else
                                word = {8'h00, shreg};
                            next_seq();
                        end else begin
                            enter(PH_RX0);
                        end
                    end
                    PH_STP2: begin
                        if (op_l == OP_READ_PAIR && !on_second) begin
                            on_second = 1'b1;
                            seq_pos = SEQ_START;
                            begin_seq();
                        end else begin
                            r.done_res = 1'b1;
                            r.read_data = word;
                            enter(PH_IDLE);
                        end
                    end
                    PH_AST2: begin
                        r.done_res = 1'b1;
                        r.ack_missed = 1'b1;
                        enter(PH_IDLE);
                    end
                    default: ph = phase_t'(ph + 5'd1);
                endcase
            end
            levels_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 100) $display("mismatch at result %0d: %s", results_seen, what);
        endtask

        task check_levels(logic [M_TDATA_W-1:0] d);
            result_t got;
            result_t want;
            got = d[$bits(result_t)-1:0];
            if (levels_q.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = levels_q.pop_front();
                if (got.scl_out !== want.scl_out)
                    report_mismatch($sformatf("scl_out %b want %b", got.scl_out, want.scl_out));
                if (got.sda_low !== want.sda_low)
                    report_mismatch($sformatf("sda_low %b want %b", got.sda_low, want.sda_low));
                if (got.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res %b want %b",
                                              got.busy_res, want.busy_res));
                if (got.done_res !== want.done_res)
                    report_mismatch($sformatf("done_res %b want %b",
                                              got.done_res, want.done_res));
                if (got.read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %h want %h",
                                              got.read_data, want.read_data));
                if (got.ack_missed !== want.ack_missed)
                    report_mismatch($sformatf("ack_missed %b want %b",
                                              got.ack_missed, want.ack_missed));
            end
            results_seen++;
        endtask
    endclass

endpackage

### verif/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cram_pkg::*;
    import i2cram_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int NO_CAP      = 1000000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // req_valid, opcode, reg_addr, write_data, sda_in
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // scl_out, sda_low, busy_res, done_res, read_data, ack_missed
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bus_level_scoreboard sb;

    int ticks_sent = 0;
    int ack_no = 0;
    bit in_ack = 1'b0;
    int slack_pct = 0;
    bit src_calm = 1'b0;
    bit sink_calm = 1'b0;
    int sink_hold = 0;
    int unsigned stall_cycles = 0;

    i2c_register_access_master_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_levels(m_axis_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : sink
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
                sink_hold = sink_hold - 1;
            end else begin
                m_axis_tready <= sink_calm || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    // slave side of the bus: acks unless told to refuse the n-th one, or refused at random by slack_pct
    function automatic bus_tick_t bus_tick(int miss_no);
        bus_tick_t t;
        t = bus_tick_t'(20'($urandom));
        if (sb.ph == PH_ACKW) begin
            if (!in_ack) begin
                ack_no++;
                in_ack = 1'b1;
            end
            t.sda_in = (ack_no == miss_no || $urandom_range(0, 99) < slack_pct) ? 1'b1 : 1'b0;
        end else begin
            in_ack = 1'b0;
        end
        return t;
    endfunction

    task automatic push_tick(input bus_tick_t t);
        if (!src_calm && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(t);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.take_tick(t);
        ticks_sent++;
    endtask

    task automatic idle_ticks(input int n);
        bus_tick_t t;
        repeat (n) begin
            t = bus_tick(0);
            if (sb.ph == PH_IDLE && t.req_valid && t.opcode != OP_RESERVED) t.req_valid = 1'b0;
            push_tick(t);
        end
    endtask

    // offer one request, then clock the bus until it is idle again or the cap is hit
    task automatic run_transfer(input logic [1:0] op, input logic [7:0] ra,
                                input logic [7:0] wd, input int miss_no, input int max_ticks);
        bus_tick_t t;
        int n;
        if (sb.ph == PH_IDLE) begin
            ack_no = 0;
            in_ack = 1'b0;
        end
        t = bus_tick(miss_no);
        t.req_valid  = 1'b1;
        t.opcode     = op;
        t.reg_addr   = ra;
        t.write_data = wd;
        push_tick(t);
        n = 1;
        while (sb.ph != PH_IDLE && n < max_ticks) begin
            push_tick(bus_tick(miss_no));
            n++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_bus(input logic [7:0] dev, input logic [15:0] qlen,
                           input logic [7:0] lim);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEV_ADDR;
        cfg_wdata <= {8'h00, dev};
        @(posedge aclk);
        cfg_index <= CFG_PHASE_TICKS;
        cfg_wdata <= qlen;
        @(posedge aclk);
        cfg_index <= CFG_ACK_LIMIT;
        cfg_wdata <= {8'h00, lim};
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(CFG_DEV_ADDR, {8'h00, dev});
        sb.write_reg(CFG_PHASE_TICKS, qlen);
        sb.write_reg(CFG_ACK_LIMIT, {8'h00, lim});
    endtask

    task automatic random_phase(input logic [7:0] dev, input logic [15:0] qlen,
                                input logic [7:0] lim, input int slack, input int budget,
                                input bit calm, input int hold);
        int target;
        int miss;
        logic [1:0] op;
        set_bus(dev, qlen, lim);
        slack_pct = slack;
        src_calm  = calm;
        sink_calm = calm;
        if (hold > 0) sink_hold = hold;
        target = ticks_sent + budget;
        while (ticks_sent < target) begin
            if ($urandom_range(0, 3) == 0) idle_ticks($urandom_range(1, 4));
            if ($urandom_range(0, 19) == 0) drain();
            if (!calm && $urandom_range(0, 49) == 0) sink_hold = $urandom_range(20, 80);
            op   = ($urandom_range(0, 19) == 0) ? OP_RESERVED : 2'($urandom_range(0, 2));
            miss = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 6) : 0;
            run_transfer(op, 8'($urandom), 8'($urandom), miss, target - ticks_sent);
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    initial begin : stimulus
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // default registers: slow quarters, only the opening of one write
        run_transfer(OP_WRITE, 8'h5A, 8'hC3, 0, 300);

        set_bus(8'hFE, 16'd1, 8'd4);
        slack_pct = 0;
        // first one lands while the write is still running
        run_transfer(OP_RESERVED, 8'h00, 8'h00, 0, NO_CAP);
        run_transfer(OP_RESERVED, 8'hFF, 8'hFF, 0, NO_CAP);
        run_transfer(OP_WRITE, 8'hFF, 8'h00, 0, NO_CAP);
        run_transfer(OP_WRITE, 8'h00, 8'hFF, 0, NO_CAP);
        run_transfer(OP_READ, 8'hA5, 8'h00, 0, NO_CAP);
        run_transfer(OP_READ_PAIR, 8'hFF, 8'h00, 0, NO_CAP);
        // refused acks: data byte, read address, first half, second half
        run_transfer(OP_WRITE, 8'h12, 8'h34, 3, NO_CAP);
        run_transfer(OP_READ, 8'h56, 8'h00, 3, NO_CAP);
        run_transfer(OP_READ_PAIR, 8'h78, 8'h00, 1, NO_CAP);
        run_transfer(OP_READ_PAIR, 8'h9A, 8'h00, 5, NO_CAP);

        // device address wraps on read, zero quarter and zero ack limit
        set_bus(8'hFF, 16'd0, 8'd0);
        slack_pct = 40;
        run_transfer(OP_READ, 8'h3C, 8'h00, 0, NO_CAP);
        run_transfer(OP_READ_PAIR, 8'h80, 8'h00, 0, NO_CAP);

        random_phase(8'($urandom), 16'd1, 8'd255, 10, 120, 1'b0, 0);
        random_phase(8'h01, 16'd3, 8'd1, 15, 100, 1'b0, 0);
        random_phase(8'($urandom), 16'd0, 8'($urandom_range(1, 8)), 30, 100, 1'b0, 80);
        random_phase(8'h00, 16'd2, 8'd255, 5, 100, 1'b1, 0);
        random_phase(8'($urandom), 16'hFFFF, 8'hFF, 5, 80, 1'b0, 0);
        random_phase(8'($urandom), 16'd1, 8'($urandom_range(2, 20)), 20, 120, 1'b0, 0);
        random_phase(8'hD0, 16'd2, 8'd3, 25, 100, 1'b0, 0);

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/i2cram_pkg.sv
rtl/core/i2cram_front.sv
rtl/core/i2cram_queue.sv
rtl/core/i2cram_seq.sv
rtl/core/i2c_register_access_master_unit.sv
rtl/core/i2cram_checker.sv
verif/i2cram_tb_pkg.sv
verif/tb.sv
